[sv/sld_pkg.sv]
package sld_pkg;

	localparam int MAX_OUT_WIDTH = 1024;
	localparam int TAP_LANES = 4;
	localparam int CHANNELS = 3;
	localparam int SUM_BITS = 24;
	localparam int IDX_W = $clog2(MAX_OUT_WIDTH);
	localparam int WIDTH_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int HPROD_W = 19;
	localparam int VPROD_W = 26;
	localparam int WIDE_W = 27;
	localparam int ROW_W = CHANNELS * TAP_LANES * SUM_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COEF0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COEF1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COEF2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COEF3 = 3'd4;

	typedef logic signed [15:0] coef_t;
	typedef coef_t [TAP_LANES-1:0] coef_vec_t;
	typedef logic signed [SUM_BITS-1:0] sum_t;
	typedef sum_t [CHANNELS-1:0] chan_sum_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [15:0] lin_rom_t [256];

	typedef struct packed {
		logic row_start;
		logic [7:0] red_code;
		logic [7:0] green_code;
		logic [7:0] blue_code;
		coef_t coef_lane0;
		coef_t coef_lane1;
		coef_t coef_lane2;
		coef_t coef_lane3;
		logic closes_output;
	} in_t;

	typedef struct packed {
		idx_t out_index;
		sum_t horiz_red;
		sum_t horiz_green;
		sum_t horiz_blue;
		sum_t vert_red;
		sum_t vert_green;
		sum_t vert_blue;
	} out_t;

	// Controls for the horizontal lane units.
	typedef struct packed {
		logic mul;
		logic acc;
		logic start;
		logic shift;
	} lane_ctl_t;

	// Controls for the vertical accumulator stage.
	typedef struct packed {
		logic rd;
		logic mul;
		logic wr;
	} vm_ctl_t;

	// Clamp a widened sum back to the signed accumulator range.
	function automatic sum_t sat_sum(logic signed [WIDE_W-1:0] x);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
		lo = WIDE_W'(-(64'sd1 <<< (SUM_BITS - 1)));
		if (x > hi) begin
			return hi[SUM_BITS-1:0];
		end else if (x < lo) begin
			return lo[SUM_BITS-1:0];
		end
		return x[SUM_BITS-1:0];
	endfunction

	function automatic longint unsigned mul30(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint unsigned pow5_q30(longint unsigned y);
		longint unsigned y2;
		longint unsigned y4;
		y2 = mul30(y, y);
		y4 = mul30(y2, y2);
		return mul30(y4, y);
	endfunction

	// sRGB decode table, evaluated once at elaboration.
	function automatic lin_rom_t build_lin_rom();
		lin_rom_t r;
		longint unsigned v;
		longint unsigned num;
		longint unsigned t;
		longint unsigned t2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		for (int i = 0; i < 256; i++) begin
			if (i <= 10) begin
				v = (longint'(i) * 1310720 + 32946) / 65892;
			end else begin
				num = 1000 * longint'(i) + 14025;
				t = ((num << 30) + 134512) / 269025;
				t2 = mul30(t, t);
				lo = 0;
				hi = 64'd1 << 30;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					if (pow5_q30(mid) <= t2) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				v = (t2 * lo + (64'd1 << 43)) >> 44;
			end
			if (v > 65535) begin
				v = 65535;
			end
			r[i] = v[15:0];
		end
		return r;
	endfunction

	localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

[sv/srgb_linear_separable_downscale.sv]
// Horizontal pass of a linear-light separable downscaler. Each input beat
// carries one sRGB pixel and its four horizontal tap weights; the three bytes
// are decoded to linear light through a constant table and fed to three
// channel lane units, each holding four saturating running sums. A beat that
// closes an output pixel reads that pixel's row of vertical accumulators,
// adds lane 0 weighted by the four row coefficients, writes it back, shifts
// the lanes and gives one result beat. A beat that does not close an output
// goes through the accept, multiply and accumulate steps; a closing beat adds
// read, multiply and write-back steps through the single-port accumulator
// memory. The result sits in an output register, so the next beat is taken
// while it waits; a closing beat holds before its write-back step for as
// long as the previous result has not been taken. After reset the
// accumulator memory is zeroed in a pass over all 1024 rows, during which no
// pixel is taken; configuration writes are taken at any time.
module srgb_linear_separable_downscale (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sld_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output sld_pkg::out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [sld_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [sld_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sld_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_RD,
		S_VMUL,
		S_WR
	} state_t;

	state_t state_q;
	logic out_valid_q;
	out_t out_q;
	idx_t cnt_q;
	idx_t idx_q;
	logic [WIDTH_W-1:0] width_q;
	coef_vec_t row_coef_q;

	// Payload held for the beat in flight.
	logic [15:0] lin_s1 [CHANNELS];
	coef_vec_t coef_s1;
	logic start_s1;
	logic close_s1;

	logic [WIDTH_W-1:0] w_eff;
	idx_t idx_now;
	idx_t idx_next;
	logic clr_busy;
	logic in_acc;
	lane_ctl_t lane_ctl;
	vm_ctl_t vm_ctl;
	chan_sum_t horiz;
	chan_sum_t vert;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE) && !clr_busy;
	assign in_acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_W'(MAX_OUT_WIDTH);
			row_coef_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OUTPUT_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
				REG_ROW_COEF0: row_coef_q[0] <= cfg_data;
				REG_ROW_COEF1: row_coef_q[1] <= cfg_data;
				REG_ROW_COEF2: row_coef_q[2] <= cfg_data;
				REG_ROW_COEF3: row_coef_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A width of zero acts as one and anything above the maximum as the maximum.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (width_q > WIDTH_W'(MAX_OUT_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_OUT_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if ({1'b0, cnt_q} >= w_eff) begin
			idx_now = IDX_W'(w_eff - 1'b1);
		end else begin
			idx_now = cnt_q;
		end
		if (({1'b0, idx_q} + 1'b1) < w_eff) begin
			idx_next = idx_q + 1'b1;
		end else begin
			idx_next = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lin_s1[0] <= LIN_ROM[in_data.red_code];
			lin_s1[1] <= LIN_ROM[in_data.green_code];
			lin_s1[2] <= LIN_ROM[in_data.blue_code];
			coef_s1 <= {in_data.coef_lane3, in_data.coef_lane2,
				in_data.coef_lane1, in_data.coef_lane0};
			start_s1 <= in_data.row_start;
			close_s1 <= in_data.closes_output;
		end
		if (state_q == S_ACC) begin
			idx_q <= idx_now;
		end
		if (state_q == S_WR) begin
			out_q <= '{out_index: idx_q,
				horiz_red: horiz[0], horiz_green: horiz[1], horiz_blue: horiz[2],
				vert_red: vert[0], vert_green: vert[1], vert_blue: vert[2]};
		end
	end

	// Sequencer: one beat at a time; closing beats go through the memory.
	// The write-back step waits until the output register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_MUL;
						if (in_data.row_start) begin
							cnt_q <= '0;
						end
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: state_q <= close_s1 ? S_RD : S_IDLE;
				S_RD: state_q <= S_VMUL;
				S_VMUL: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
					cnt_q <= idx_next;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign lane_ctl = '{mul: state_q == S_MUL, acc: state_q == S_ACC,
		start: start_s1, shift: state_q == S_WR};
	assign vm_ctl = '{rd: state_q == S_RD, mul: state_q == S_VMUL, wr: state_q == S_WR};

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		sld_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(lane_ctl),
			.lin(lin_s1[c]),
			.coef(coef_s1),
			.lane0(horiz[c])
		);
	end

	sld_vmerge u_vmerge (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(vm_ctl),
		.addr(idx_q),
		.horiz(horiz),
		.row_coef(row_coef_q),
		.vert(vert),
		.busy(clr_busy)
	);

	// A pending result is never overwritten by the write-back step.
	a_wr_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> !out_valid) else $error("result overwritten");

	// Results appear only at the end of the write-back step.
	a_result_from_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_WR)) else $error("stray result");

	// No pixel enters while the accumulator memory is being cleared.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ready) else $error("pixel taken during clear");

	// Memory traffic only for closing pixels.
	a_rd_needs_close: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> close_s1) else $error("read without close");

endmodule

[sv/sld_lane.sv]
module sld_lane (
	input logic clk,
	input logic arst_n,
	input sld_pkg::lane_ctl_t ctl,
	input logic [15:0] lin,
	input sld_pkg::coef_vec_t coef,
	output sld_pkg::sum_t lane0
);
	import sld_pkg::*;

	sum_t lane_q [TAP_LANES];
	logic signed [HPROD_W-1:0] prod_s1 [TAP_LANES];
	logic signed [32:0] prod [TAP_LANES];

	// Q0.16 times Q2.14, rounded half up back to 16 fraction bits.
	always_comb begin
		for (int k = 0; k < TAP_LANES; k++) begin
			prod[k] = $signed({1'b0, lin}) * coef[k] + 33'sd8192;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			for (int k = 0; k < TAP_LANES; k++) begin
				prod_s1[k] <= prod[k][32:14];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAP_LANES; k++) begin
				lane_q[k] <= '0;
			end
		end else if (ctl.acc) begin
			for (int k = 0; k < TAP_LANES; k++) begin
				lane_q[k] <= sat_sum(WIDE_W'(ctl.start ? sum_t'(0) : lane_q[k])
					+ WIDE_W'(prod_s1[k]));
			end
		end else if (ctl.shift) begin
			for (int k = 0; k < TAP_LANES - 1; k++) begin
				lane_q[k] <= lane_q[k+1];
			end
			lane_q[TAP_LANES-1] <= '0;
		end
	end

	assign lane0 = lane_q[0];

endmodule

[sv/sld_vmerge.sv]
module sld_vmerge (
	input logic clk,
	input logic arst_n,
	input sld_pkg::vm_ctl_t ctl,
	input sld_pkg::idx_t addr,
	input sld_pkg::chan_sum_t horiz,
	input sld_pkg::coef_vec_t row_coef,
	output sld_pkg::chan_sum_t vert,
	output logic busy
);
	import sld_pkg::*;

	logic [ROW_W-1:0] mem [MAX_OUT_WIDTH];
	logic [ROW_W-1:0] row_s1;
	logic [ROW_W-1:0] row_new;
	logic signed [VPROD_W-1:0] vprod_s2 [CHANNELS][TAP_LANES];
	logic signed [39:0] vprod [CHANNELS][TAP_LANES];
	logic [IDX_W:0] clr_q;

	assign busy = !clr_q[IDX_W];

	// The clearing pass walks the store once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_q[IDX_W-1:0]] <= '0;
		end else if (ctl.wr) begin
			mem[addr] <= row_new;
		end
		if (ctl.rd) begin
			row_s1 <= mem[addr];
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			for (int k = 0; k < TAP_LANES; k++) begin
				vprod[c][k] = horiz[c] * row_coef[k] + 40'sd8192;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int k = 0; k < TAP_LANES; k++) begin
					vprod_s2[c][k] <= vprod[c][k][39:14];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			for (int k = 0; k < TAP_LANES; k++) begin
				row_new[(c*TAP_LANES+k)*SUM_BITS +: SUM_BITS] = sat_sum(
					WIDE_W'($signed(row_s1[(c*TAP_LANES+k)*SUM_BITS +: SUM_BITS]))
					+ WIDE_W'(vprod_s2[c][k]));
			end
			vert[c] = row_new[c*TAP_LANES*SUM_BITS +: SUM_BITS];
		end
	end

endmodule

[test/tb_srgb_linear_separable_downscale.sv]
`timescale 1ns / 100ps

// Testbench for the horizontal pass of the linear-light downscaler.
// Pixel beats go in on the input channel, and the testbench keeps its own model
// of the block: the sRGB decode curve, the twelve horizontal lanes, the vertical
// accumulator store and the output index. Every pixel beat that is taken
// updates that model. A closing beat also queues the result beat it must give.
// A separate process takes result beats with random stalls and compares each
// one, field by field, with the oldest queued result.
module tb_srgb_linear_separable_downscale;
	import sld_pkg::*;

	localparam int QUIET_CYCLES = 10;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	srgb_linear_separable_downscale i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Model state. The vertical store starts at zero, as the block clears
	// its own memory after reset.
	logic [15:0] srgb_to_lin [256];
	longint lanes [CHANNELS][TAP_LANES];
	longint vert_store [MAX_OUT_WIDTH*CHANNELS*TAP_LANES];
	int out_pos;
	int width_reg;
	longint row_wt [TAP_LANES];

	out_t pending_results [$];
	int mismatches;
	// When set, the matching side runs without gaps or stalls.
	bit send_burst;
	bit take_burst;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Q30 product, rounded half up.
	function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	// Builds the decode curve: a straight segment for the darkest codes and
	// the 2.4 power law, taken as t^2 * t^(2/5) via a fifth-root search.
	function automatic void fill_decode_curve();
		longint unsigned val;
		longint unsigned t;
		longint unsigned tsq;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned m2;
		longint unsigned m4;
		for (int code = 0; code < 256; code++) begin
			if (code <= 10) begin
				val = (longint'(code) * 1310720 + 32946) / 65892;
			end else begin
				t = (((1000 * longint'(code) + 14025)) << 30) + 134512;
				t = t / 269025;
				tsq = q30_mul(t, t);
				lo = 0;
				hi = 64'd1 << 30;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					m2 = q30_mul(mid, mid);
					m4 = q30_mul(m2, m2);
					if (q30_mul(m4, mid) <= tsq) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				val = (tsq * lo + (64'd1 << 43)) >> 44;
			end
			if (val > 65535) begin
				val = 65535;
			end
			srgb_to_lin[code] = val[15:0];
		end
	endfunction

	function automatic longint clamp24(longint x);
		if (x > 64'sd8388607) begin
			return 64'sd8388607;
		end
		if (x < -64'sd8388608) begin
			return -64'sd8388608;
		end
		return x;
	endfunction

	// Q2.14 product rounded half up to 16 fraction bits; >>> floors.
	function automatic longint weigh_q14(longint a, longint b);
		return (a * b + 8192) >>> 14;
	endfunction

	// Advances the model by one accepted pixel and queues its result, if any.
	function automatic void accumulate_pixel(in_t p);
		longint lin [CHANNELS];
		longint cf [TAP_LANES];
		longint hsum [CHANNELS];
		longint vsum [CHANNELS];
		int w;
		int idx;
		int base;
		out_t r;
		if (p.row_start) begin
			foreach (lanes[c, k]) begin
				lanes[c][k] = 0;
			end
			out_pos = 0;
		end
		lin[0] = srgb_to_lin[p.red_code];
		lin[1] = srgb_to_lin[p.green_code];
		lin[2] = srgb_to_lin[p.blue_code];
		cf[0] = p.coef_lane0;
		cf[1] = p.coef_lane1;
		cf[2] = p.coef_lane2;
		cf[3] = p.coef_lane3;
		foreach (lanes[c, k]) begin
			lanes[c][k] = clamp24(lanes[c][k] + weigh_q14(lin[c], cf[k]));
		end
		if (!p.closes_output) begin
			return;
		end
		// Out-of-range widths are clipped, and the index sticks at the last pixel.
		w = width_reg;
		if (w < 1) begin
			w = 1;
		end
		if (w > MAX_OUT_WIDTH) begin
			w = MAX_OUT_WIDTH;
		end
		idx = (out_pos >= w) ? w - 1 : out_pos;
		for (int c = 0; c < CHANNELS; c++) begin
			hsum[c] = lanes[c][0];
			base = (idx * CHANNELS + c) * TAP_LANES;
			for (int k = 0; k < TAP_LANES; k++) begin
				vert_store[base + k] = clamp24(vert_store[base + k] +
					weigh_q14(hsum[c], row_wt[k]));
			end
			vsum[c] = vert_store[base];
			for (int k = 0; k < TAP_LANES - 1; k++) begin
				lanes[c][k] = lanes[c][k + 1];
			end
			lanes[c][TAP_LANES - 1] = 0;
		end
		r.out_index = idx_t'(idx);
		r.horiz_red = sum_t'(hsum[0]);
		r.horiz_green = sum_t'(hsum[1]);
		r.horiz_blue = sum_t'(hsum[2]);
		r.vert_red = sum_t'(vsum[0]);
		r.vert_green = sum_t'(vsum[1]);
		r.vert_blue = sum_t'(vsum[2]);
		out_pos = (idx + 1 < w) ? idx + 1 : idx;
		pending_results.push_back(r);
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Result side: draws a stall for every beat, then holds ready until a
	// beat is taken. Ready is only lowered when the stall is not zero, so it
	// never drops and rises within one time step.
	initial begin
		int stall;
		out_t want;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = take_burst ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if (pending_results.size() == 0) begin
				$error("result beat with no result pending, out_index %0d",
					out_data.out_index);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_index", want.out_index, out_data.out_index);
				check_field("horiz_red", want.horiz_red, out_data.horiz_red);
				check_field("horiz_green", want.horiz_green, out_data.horiz_green);
				check_field("horiz_blue", want.horiz_blue, out_data.horiz_blue);
				check_field("vert_red", want.vert_red, out_data.vert_red);
				check_field("vert_green", want.vert_green, out_data.vert_green);
				check_field("vert_blue", want.vert_blue, out_data.vert_blue);
			end
		end
	end

	// Watchdog: any beat on any channel restarts the count. The limit
	// covers the memory clearing pass after reset with room to spare.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("srgb_linear_separable_downscale regression: fail");
				$finish;
			end
		end
	end

	// Sends one pixel beat after a random gap. Valid stays high from one
	// beat to the next when the gap is zero.
	task automatic send_pixel(in_t p);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		accumulate_pixel(p);
	endtask

	// One register write. The caller lowers cfg_valid after its last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_OUTPUT_WIDTH: width_reg = int'(value[10:0]);
			REG_ROW_COEF0: row_wt[0] = longint'(signed'(value));
			REG_ROW_COEF1: row_wt[1] = longint'(signed'(value));
			REG_ROW_COEF2: row_wt[2] = longint'(signed'(value));
			REG_ROW_COEF3: row_wt[3] = longint'(signed'(value));
			default: ;
		endcase
	endtask

	// Writes all five registers, with the block idle.
	task automatic set_regs(int width, coef_t w0, coef_t w1, coef_t w2, coef_t w3);
		write_reg(REG_OUTPUT_WIDTH, CFG_DATA_W'(width));
		write_reg(REG_ROW_COEF0, w0);
		write_reg(REG_ROW_COEF1, w1);
		write_reg(REG_ROW_COEF2, w2);
		write_reg(REG_ROW_COEF3, w3);
		cfg_valid <= 1'b0;
	endtask

	// Lets every pending result arrive, then gives a pixel that closes
	// nothing the time it may still need inside the block.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	function automatic in_t make_pixel(bit start, bit close, bit full_range);
		in_t p;
		p.row_start = start;
		p.closes_output = close;
		p.red_code = 8'($urandom);
		p.green_code = 8'($urandom);
		p.blue_code = 8'($urandom);
		if (full_range) begin
			p.coef_lane0 = coef_t'($urandom);
			p.coef_lane1 = coef_t'($urandom);
			p.coef_lane2 = coef_t'($urandom);
			p.coef_lane3 = coef_t'($urandom);
		end else begin
			// Typical filter taps: mostly positive, below one.
			p.coef_lane0 = coef_t'($urandom_range(0, 18000) - 2000);
			p.coef_lane1 = coef_t'($urandom_range(0, 18000) - 2000);
			p.coef_lane2 = coef_t'($urandom_range(0, 18000) - 2000);
			p.coef_lane3 = coef_t'($urandom_range(0, 18000) - 2000);
		end
		return p;
	endfunction

	function automatic in_t fixed_pixel(bit start, bit close, byte unsigned code, coef_t cf);
		in_t p;
		p.row_start = start;
		p.closes_output = close;
		p.red_code = code;
		p.green_code = code;
		p.blue_code = code;
		p.coef_lane0 = cf;
		p.coef_lane1 = cf;
		p.coef_lane2 = cf;
		p.coef_lane3 = cf;
		return p;
	endfunction

	// Extremes of every field, both ends of the decode curve and the join of
	// its two segments, a row start that also closes, pixels that close
	// nothing, the index running into the end of a short row, a width of
	// zero and one above the store size, and the width lowered mid-row.
	task automatic test_directed();
		send_burst = 1'b0;
		take_burst = 1'b0;
		set_regs(3, 16'sh4000, -16'sh4000, 16'sh7fff, -16'sh8000);
		send_pixel(fixed_pixel(1'b1, 1'b1, 8'd255, 16'sh7fff));
		send_pixel(fixed_pixel(1'b0, 1'b0, 8'd0, -16'sh8000));
		send_pixel(fixed_pixel(1'b0, 1'b0, 8'd10, 16'sh4000));
		send_pixel(fixed_pixel(1'b0, 1'b1, 8'd11, -16'sh8000));
		send_pixel(fixed_pixel(1'b0, 1'b1, 8'd255, -16'sh8000));
		send_pixel(fixed_pixel(1'b0, 1'b1, 8'd128, 16'sh7fff));
		send_pixel(fixed_pixel(1'b0, 1'b1, 8'd255, 16'sh7fff));
		send_pixel(fixed_pixel(1'b1, 1'b1, 8'd1, 16'sh0001));
		drain();
		set_regs(0, -16'sh8000, 16'sh7fff, 16'sh0000, 16'sh2000);
		send_pixel(fixed_pixel(1'b1, 1'b1, 8'd255, 16'sh7fff));
		send_pixel(fixed_pixel(1'b0, 1'b1, 8'd200, 16'sh4000));
		drain();
		set_regs(2047, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_pixel(fixed_pixel(1'b1, 1'b1, 8'd255, 16'sh7fff));
		for (int i = 0; i < 5; i++) begin
			send_pixel(make_pixel(1'b0, 1'b1, 1'b1));
		end
		drain();
		// Only four output pixels now, while the index already stands at six.
		set_regs(4, 16'sh4000, 16'sh1000, -16'sh1000, 16'sh0800);
		send_pixel(make_pixel(1'b0, 1'b1, 1'b1));
		send_pixel(make_pixel(1'b0, 1'b1, 1'b0));
		drain();
	endtask

	// Random rows under one register setting. Most stimulus is well-formed
	// rows: a row start, then output pixels built from a few pixels each.
	// Some rows run a long stretch of extreme taps to saturate the lanes, and
	// the rest is noise with random start and close marks.
	task automatic random_phase(int pixels, bit full_range, bit pause_often);
		int sent;
		int kind;
		int outs;
		int taps;
		in_t p;
		sent = 0;
		while (sent < pixels) begin
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				outs = $urandom_range(1, (width_reg > 0 && width_reg < 6) ? width_reg + 2 : 6);
				for (int o = 0; o < outs; o++) begin
					taps = $urandom_range(1, 4);
					for (int t = 0; t < taps; t++) begin
						p = make_pixel(o == 0 && t == 0, t == taps - 1, full_range);
						send_pixel(p);
						sent++;
					end
				end
			end else if (kind < 90) begin
				p = fixed_pixel(1'b1, 1'b0, 8'd255, ($urandom_range(0, 1) != 0) ?
					16'sh7fff : -16'sh8000);
				for (int t = 0; t < 70; t++) begin
					p.row_start = (t == 0);
					p.closes_output = (t == 69);
					send_pixel(p);
					sent++;
				end
			end else begin
				p = make_pixel($urandom_range(0, 3) == 0, $urandom_range(0, 1), 1'b1);
				send_pixel(p);
				sent++;
			end
			// Hold the sender until every result so far has come out.
			if (pause_often && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0) begin
					@(posedge clk);
				end
			end
		end
		drain();
	endtask

	function automatic int pick_width();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 2047;
			2: return 1024;
			3: return $urandom_range(1, 1024);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic coef_t pick_row_weight();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return -16'sh8000;
			2: return coef_t'($urandom);
			default: return coef_t'($urandom_range(0, 16384));
		endcase
	endfunction

	task automatic test_random_settings();
		for (int ph = 0; ph < 12; ph++) begin
			send_burst = ($urandom_range(0, 3) == 0);
			take_burst = ($urandom_range(0, 3) == 0);
			set_regs(pick_width(), pick_row_weight(), pick_row_weight(),
				pick_row_weight(), pick_row_weight());
			random_phase(140, ph % 3 == 0, 1'b0);
		end
	endtask

	// The sender pauses for the block to empty, at random points.
	task automatic test_sender_pause();
		send_burst = 1'b0;
		take_burst = 1'b0;
		set_regs(5, 16'sh4000, 16'sh2000, -16'sh2000, 16'sh1000);
		random_phase(150, 1'b0, 1'b1);
	endtask

	initial begin
		mismatches = 0;
		send_burst = 1'b0;
		take_burst = 1'b0;
		out_pos = 0;
		width_reg = MAX_OUT_WIDTH;
		foreach (row_wt[k]) begin
			row_wt[k] = 0;
		end
		foreach (lanes[c, k]) begin
			lanes[c][k] = 0;
		end
		foreach (vert_store[i]) begin
			vert_store[i] = 0;
		end
		fill_decode_curve();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_settings();
		test_sender_pause();

		drain();
		if (mismatches == 0) begin
			$display("srgb_linear_separable_downscale regression: pass");
		end else begin
			$display("srgb_linear_separable_downscale regression: fail");
		end
		$finish;
	end

endmodule

[files.f]
sv/sld_pkg.sv
sv/sld_lane.sv
sv/sld_vmerge.sv
sv/srgb_linear_separable_downscale.sv
test/tb_srgb_linear_separable_downscale.sv
